FILE: hdl/ntint_pkg.sv
// Shared widths, codes and reset values of the normalized table interpolator.
package ntint_pkg;

  localparam int DataW   = 16;
  localparam int IdxW    = 4;
  localparam int LenW    = 5;
  localparam int CfgIdxW = 2;

  localparam int TableDepthDef = 16;
  localparam int FracBitsDef   = 6;

  // Configuration register indexes; the fourth code is unused.
  typedef enum logic [CfgIdxW-1:0] {
    CfgSpanLow  = 2'd0,
    CfgSpanHigh = 2'd1,
    CfgTableLen = 2'd2
  } cfg_reg_e;

  localparam logic OpWrite = 1'b0;
  localparam logic OpMap   = 1'b1;

  localparam logic StatOk       = 1'b0;
  localparam logic StatZeroSpan = 1'b1;

  localparam logic signed [DataW-1:0] SpanLowRst  = 16'sd0;
  localparam logic signed [DataW-1:0] SpanHighRst = 16'sd64;
  localparam logic [LenW-1:0]         TableLenRst = 5'd16;

  localparam int SatMax = 32767;
  localparam int SatMin = -32768;

endpackage

FILE: hdl/ntint_if.sv
// Channel interfaces of the normalized table interpolator: items, results, config writes.
interface ntint_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [ntint_pkg::DataW-1:0]  sample;
  logic        [ntint_pkg::IdxW-1:0]   entry_index;
  logic signed [ntint_pkg::DataW-1:0]  entry_data;

  modport source (output valid, output op, output sample, output entry_index,
                  output entry_data, input ready);
  modport sink   (input valid, input op, input sample, input entry_index,
                  input entry_data, output ready);
endinterface

interface ntint_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ntint_pkg::DataW-1:0]  mapped;
  logic                                status;

  modport source (output valid, output mapped, output status, input ready);
  modport sink   (input valid, input mapped, input status, output ready);
endinterface

interface ntint_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ntint_pkg::CfgIdxW-1:0]       index;
  logic [ntint_pkg::DataW-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/ntint_tbl_ram.sv
// Table memory: one write port and two registered read ports.
module ntint_tbl_ram #(
  parameter int Depth = ntint_pkg::TableDepthDef,
  localparam int Aw   = $clog2(Depth)
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [Aw-1:0]                      waddr_i,
  input  logic signed [ntint_pkg::DataW-1:0] wdata_i,
  input  logic                               re_i,
  input  logic [Aw-1:0]                      raddr_a_i,
  input  logic [Aw-1:0]                      raddr_b_i,
  output logic signed [ntint_pkg::DataW-1:0] rdata_a_o,
  output logic signed [ntint_pkg::DataW-1:0] rdata_b_o
);

  logic signed [ntint_pkg::DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

FILE: hdl/normalized_table_interpolator.sv
// Normalized table interpolator: span normalize, divide pipeline, table read and blend.
//
// Channels: item_i takes words with op = write (load entry_data into slot entry_index)
// or op = map (interpolate the table at sample). result_o returns exactly one word per
// item, in order: mapped and status. cfg_i writes span_low, span_high and table_len;
// it is always ready and may be written only while no item is in flight.
//
// Throughput: one item per cycle while result_o does not stall. The pipeline holds the
// quotient stages, which retire one quotient bit per stage, followed by position,
// table read, multiply and output stages. Table writes land at the read stage in item
// order, so a map sees every write accepted before it and none accepted after it.
//
// Reset clears all valid bits and loads the register defaults; table contents stay
// undefined until written. When the receiver stalls the output word holds, and empty
// stages behind it keep filling, so item_i stays ready until the pipeline is full.
module normalized_table_interpolator #(
  parameter int TABLE_DEPTH = ntint_pkg::TableDepthDef,
  parameter int FRAC_BITS   = ntint_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ntint_in_if.sink          item_i,
  ntint_out_if.source       result_o,
  ntint_cfg_if.sink         cfg_i
);

  localparam int Aw    = $clog2(TABLE_DEPTH);
  localparam int DifW  = ntint_pkg::DataW + 1;
  localparam int PosW  = FRAC_BITS + 1 + Aw;
  localparam int PW    = ntint_pkg::DataW + FRAC_BITS + 2;
  localparam int SPos  = FRAC_BITS + 1;
  localparam int SRd   = FRAC_BITS + 2;
  localparam int SPrd  = FRAC_BITS + 3;
  localparam int SOut  = FRAC_BITS + 4;
  localparam int NS    = FRAC_BITS + 5;

  typedef struct packed {
    logic                               op;
    logic [ntint_pkg::IdxW-1:0]         idx;
    logic signed [ntint_pkg::DataW-1:0] data;
    logic                               zero_span;
    logic                               sat_zero;
    logic                               sat_one;
    logic [DifW-1:0]                    rem;
    logic [DifW-1:0]                    den;
    logic [FRAC_BITS-1:0]               quo;
  } div_t;

  // Configuration registers
  logic signed [ntint_pkg::DataW-1:0] span_low_q, span_high_q;
  logic [ntint_pkg::LenW-1:0]         table_len_q;

  // Pipeline control
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  // Divider stages
  div_t dv_q   [FRAC_BITS+1];
  div_t dv_nxt [FRAC_BITS+1];

  // Position stage
  logic                               pos_op_q, pos_zero_q;
  logic [ntint_pkg::IdxW-1:0]         pos_idx_q;
  logic signed [ntint_pkg::DataW-1:0] pos_data_q;
  logic [PosW-1:0]                    pos_q, pos_d;
  logic [Aw-1:0]                      pos_len_q, len_m1;
  logic [Aw-1:0]                      pos_lo, pos_hi;
  logic [FRAC_BITS:0]                 t_val;
  logic                               tbl_we;

  // Read stage
  logic                               rd_op_q, rd_zero_q;
  logic [FRAC_BITS-1:0]               rd_frac_q;
  logic signed [ntint_pkg::DataW-1:0] rd_lo_data, rd_hi_data, hi_gated;
  logic [FRAC_BITS:0]                 w_lo;

  // Product stage
  logic                               prd_op_q, prd_zero_q;
  logic signed [PW-1:0]               prd_lo_q, prd_hi_q, prd_lo_d, prd_hi_d;
  logic signed [PW:0]                 blend_sum;
  logic signed [ntint_pkg::DataW-1:0] blend_sat;

  // Output stage
  logic                               out_op_q, out_status_q, out_status_d;
  logic signed [ntint_pkg::DataW-1:0] out_mapped_q, out_mapped_d;

  // One restoring step: shift the remainder and retire one quotient bit.
  function automatic div_t div_step(input div_t cur);
    div_t          nxt;
    logic [DifW:0] r2;
    logic          ge;
    nxt = cur;
    r2  = {cur.rem, 1'b0};
    ge  = (r2 >= {1'b0, cur.den});
    nxt.rem = ge ? DifW'(r2 - {1'b0, cur.den}) : DifW'(r2);
    nxt.quo = FRAC_BITS'({cur.quo, ge});
    return nxt;
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_low_q  <= ntint_pkg::SpanLowRst;
      span_high_q <= ntint_pkg::SpanHighRst;
      table_len_q <= ntint_pkg::TableLenRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ntint_pkg::CfgSpanLow:  span_low_q  <= $signed(cfg_i.data);
        ntint_pkg::CfgSpanHigh: span_high_q <= $signed(cfg_i.data);
        ntint_pkg::CfgTableLen: table_len_q <= ntint_pkg::LenW'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || result_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign item_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= item_i.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- normalize
  always_comb begin
    logic signed [DifW-1:0] diff, span;
    logic [DifW-1:0]        abs_d, abs_s;
    diff  = DifW'(item_i.sample) - DifW'(span_low_q);
    span  = DifW'(span_high_q) - DifW'(span_low_q);
    abs_d = diff[DifW-1] ? DifW'(-diff) : DifW'(diff);
    abs_s = span[DifW-1] ? DifW'(-span) : DifW'(span);
    dv_nxt[0].op        = item_i.op;
    dv_nxt[0].idx       = item_i.entry_index;
    dv_nxt[0].data      = item_i.entry_data;
    dv_nxt[0].zero_span = (span == '0);
    // opposite signs truncate to zero or below; a ratio of one or more clamps to one
    dv_nxt[0].sat_zero  = (diff == '0) || (diff[DifW-1] != span[DifW-1]);
    dv_nxt[0].sat_one   = (abs_d >= abs_s);
    dv_nxt[0].rem       = abs_d;
    dv_nxt[0].den       = abs_s;
    dv_nxt[0].quo       = '0;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      dv_nxt[k] = div_step(dv_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= FRAC_BITS; k++) begin
      if (adv[k]) begin
        dv_q[k] <= dv_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------- position
  always_comb begin
    if (32'(table_len_q) > 32'(TABLE_DEPTH)) begin
      len_m1 = Aw'(TABLE_DEPTH - 1);
    end else if (table_len_q == '0) begin
      len_m1 = '0;
    end else begin
      len_m1 = Aw'(table_len_q - 1'b1);
    end
  end

  always_comb begin
    priority if (dv_q[FRAC_BITS].sat_zero) begin
      t_val = '0;
    end else if (dv_q[FRAC_BITS].sat_one) begin
      t_val = {1'b1, FRAC_BITS'(0)};
    end else begin
      t_val = {1'b0, dv_q[FRAC_BITS].quo};
    end
    pos_d = PosW'(t_val) * PosW'(len_m1);
  end

  always_ff @(posedge clk_i) begin
    if (adv[SPos]) begin
      pos_op_q   <= dv_q[FRAC_BITS].op;
      pos_idx_q  <= dv_q[FRAC_BITS].idx;
      pos_data_q <= dv_q[FRAC_BITS].data;
      pos_zero_q <= dv_q[FRAC_BITS].zero_span;
      pos_q      <= pos_d;
      pos_len_q  <= len_m1;
    end
  end

  assign pos_lo = pos_q[FRAC_BITS +: Aw];
  assign pos_hi = (pos_lo == pos_len_q) ? pos_lo : Aw'(pos_lo + 1'b1);

  // Writes land here, in item order with the reads of map words.
  assign tbl_we = adv[SRd] && v_q[SPos] && (pos_op_q == ntint_pkg::OpWrite) &&
                  (32'(pos_idx_q) < 32'(TABLE_DEPTH));

  ntint_tbl_ram #(
    .Depth (TABLE_DEPTH)
  ) u_tbl_ram (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (Aw'(pos_idx_q)),
    .wdata_i   (pos_data_q),
    .re_i      (adv[SRd]),
    .raddr_a_i (pos_lo),
    .raddr_b_i (pos_hi),
    .rdata_a_o (rd_lo_data),
    .rdata_b_o (rd_hi_data)
  );

  always_ff @(posedge clk_i) begin
    if (adv[SRd]) begin
      rd_op_q   <= pos_op_q;
      rd_zero_q <= pos_zero_q;
      rd_frac_q <= pos_q[FRAC_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- blend
  always_comb begin
    w_lo     = {1'b1, FRAC_BITS'(0)} - {1'b0, rd_frac_q};
    // upper entry has zero weight at a whole position; drop it
    hi_gated = (rd_frac_q == '0) ? '0 : rd_hi_data;
    prd_lo_d = PW'(rd_lo_data) * PW'($signed({1'b0, w_lo}));
    prd_hi_d = PW'(hi_gated) * PW'($signed({2'b00, rd_frac_q}));
  end

  always_ff @(posedge clk_i) begin
    if (adv[SPrd]) begin
      prd_op_q   <= rd_op_q;
      prd_zero_q <= rd_zero_q;
      prd_lo_q   <= prd_lo_d;
      prd_hi_q   <= prd_hi_d;
    end
  end

  always_comb begin
    blend_sum = (PW+1)'(prd_lo_q >>> FRAC_BITS) + (PW+1)'(prd_hi_q >>> FRAC_BITS);
    priority if (blend_sum > (PW+1)'(ntint_pkg::SatMax)) begin
      blend_sat = ntint_pkg::DataW'(ntint_pkg::SatMax);
    end else if (blend_sum < (PW+1)'(ntint_pkg::SatMin)) begin
      blend_sat = ntint_pkg::DataW'(ntint_pkg::SatMin);
    end else begin
      blend_sat = ntint_pkg::DataW'(blend_sum);
    end
    if (prd_op_q == ntint_pkg::OpWrite || prd_zero_q) begin
      out_mapped_d = '0;
    end else begin
      out_mapped_d = blend_sat;
    end
    out_status_d = (prd_op_q == ntint_pkg::OpMap && prd_zero_q) ?
                   ntint_pkg::StatZeroSpan : ntint_pkg::StatOk;
  end

  always_ff @(posedge clk_i) begin
    if (adv[SOut]) begin
      out_op_q     <= prd_op_q;
      out_mapped_q <= out_mapped_d;
      out_status_q <= out_status_d;
    end
  end

  assign result_o.valid  = v_q[SOut];
  assign result_o.mapped = out_mapped_q;
  assign result_o.status = out_status_q;

  // ---------------------------------------------------------------- checks
  a_write_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && out_op_q == ntint_pkg::OpWrite |->
      result_o.mapped == '0 && result_o.status == ntint_pkg::StatOk)
    else $error("write word returned a nonzero result");

  a_zero_span_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.status == ntint_pkg::StatZeroSpan |->
      result_o.mapped == '0 && out_op_q == ntint_pkg::OpMap)
    else $error("zero span flag on a word with a mapped value");

  a_lo_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SPos] |-> pos_lo <= pos_len_q)
    else $error("lower index beyond last entry in use");

  a_hi_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SPos] |-> (pos_hi == pos_lo) || (pos_hi == Aw'(pos_lo + 1'b1)))
    else $error("upper index not adjacent to lower index");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> v_q[0])
    else $error("accepted word lost at pipeline entry");

endmodule

FILE: verif/normalized_table_interpolator_tb.sv
// Self-checking testbench for the normalized table interpolator.
module normalized_table_interpolator_tb;

  localparam int One    = 1 << ntint_pkg::FracBitsDef;
  localparam int Settle = ntint_pkg::FracBitsDef + 6;
  localparam int Limit  = 300000;

  typedef enum logic [1:0] {
    StepItem,
    StepCfg,
    StepDrain
  } step_kind_e;

  typedef struct {
    step_kind_e                          kind;
    logic                                op;
    logic signed [ntint_pkg::DataW-1:0]  sample;
    logic        [ntint_pkg::IdxW-1:0]   entry_index;
    logic signed [ntint_pkg::DataW-1:0]  entry_data;
    ntint_pkg::cfg_reg_e                 cfg_sel;
    logic        [ntint_pkg::DataW-1:0]  cfg_data;
  } step_t;

  typedef struct {
    logic signed [ntint_pkg::DataW-1:0] mapped;
    logic                               status;
  } result_t;

  logic clk_i;
  logic rst_ni;

  ntint_in_if  item_if ();
  ntint_out_if res_if ();
  ntint_cfg_if cfg_if ();

  normalized_table_interpolator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // Shadow of the block's registers and table, updated at each accepted word.
  logic signed [ntint_pkg::DataW-1:0] span_lo_q;
  logic signed [ntint_pkg::DataW-1:0] span_hi_q;
  logic        [ntint_pkg::LenW-1:0]  len_q;
  logic signed [ntint_pkg::DataW-1:0] table_copy [ntint_pkg::TableDepthDef];

  step_t   pending[$];
  result_t expected_results[$];
  step_t   cur_item;

  bit item_busy, cfg_busy, calm_tx, calm_rx;
  int gap_left, stall_left, quiet;
  int items_sent, maps_sent, results_seen, errors, settings, cycles;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic result_t interpolate(logic signed [ntint_pkg::DataW-1:0] s);
    result_t r;
    longint  span, t, pos, frac, acc;
    int      len, lo_i, hi_i;
    r.mapped = '0;
    r.status = ntint_pkg::StatOk;
    span = longint'(span_hi_q) - longint'(span_lo_q);
    if (span == 0) begin
      r.status = ntint_pkg::StatZeroSpan;
      return r;
    end
    t = ((longint'(s) - longint'(span_lo_q)) * One) / span;
    if (t < 0) t = 0;
    if (t > One) t = One;
    len = int'(len_q);
    if (len == 0) len = 1;
    if (len > ntint_pkg::TableDepthDef) len = ntint_pkg::TableDepthDef;
    pos  = t * (len - 1);
    lo_i = int'(pos >>> ntint_pkg::FracBitsDef);
    frac = pos & (One - 1);
    hi_i = lo_i + 1;
    if (hi_i > len - 1) hi_i = len - 1;
    if (lo_i > len - 1) lo_i = len - 1;
    // arithmetic shift floors each weighted term
    acc = ((longint'(table_copy[lo_i]) * (One - frac)) >>> ntint_pkg::FracBitsDef)
        + ((longint'(table_copy[hi_i]) * frac) >>> ntint_pkg::FracBitsDef);
    if (acc > ntint_pkg::SatMax) acc = ntint_pkg::SatMax;
    if (acc < ntint_pkg::SatMin) acc = ntint_pkg::SatMin;
    r.mapped = acc[ntint_pkg::DataW-1:0];
    return r;
  endfunction

  // Pick a sample around the span so most maps land inside the table.
  function automatic logic signed [ntint_pkg::DataW-1:0] sample_near(
      logic signed [ntint_pkg::DataW-1:0] a, logic signed [ntint_pkg::DataW-1:0] b);
    longint lo_v, hi_v, v;
    lo_v = (a < b) ? a : b;
    hi_v = (a < b) ? b : a;
    v = lo_v - 64 + longint'($urandom_range(0, int'(hi_v - lo_v) + 128));
    if (v > ntint_pkg::SatMax) v = ntint_pkg::SatMax;
    if (v < ntint_pkg::SatMin) v = ntint_pkg::SatMin;
    return v[ntint_pkg::DataW-1:0];
  endfunction

  function automatic step_t blank_step();
    step_t s;
    s.kind        = StepItem;
    s.op          = ntint_pkg::OpWrite;
    s.sample      = '0;
    s.entry_index = '0;
    s.entry_data  = '0;
    s.cfg_sel     = ntint_pkg::CfgSpanLow;
    s.cfg_data    = '0;
    return s;
  endfunction

  task automatic push_write(logic [ntint_pkg::IdxW-1:0] idx,
                            logic signed [ntint_pkg::DataW-1:0] data);
    step_t s;
    s = blank_step();
    s.kind        = StepItem;
    s.op          = ntint_pkg::OpWrite;
    s.sample      = ntint_pkg::DataW'($urandom);
    s.entry_index = idx;
    s.entry_data  = data;
    pending.push_back(s);
  endtask

  task automatic push_map(logic signed [ntint_pkg::DataW-1:0] smp);
    step_t s;
    s = blank_step();
    s.kind        = StepItem;
    s.op          = ntint_pkg::OpMap;
    s.sample      = smp;
    s.entry_index = ntint_pkg::IdxW'($urandom);
    s.entry_data  = ntint_pkg::DataW'($urandom);
    pending.push_back(s);
  endtask

  task automatic push_drain();
    step_t s;
    s = blank_step();
    s.kind = StepDrain;
    pending.push_back(s);
  endtask

  task automatic push_setting(logic signed [ntint_pkg::DataW-1:0] lo,
                              logic signed [ntint_pkg::DataW-1:0] hi,
                              logic [ntint_pkg::LenW-1:0] len);
    step_t s;
    s = blank_step();
    s.kind     = StepCfg;
    s.cfg_sel  = ntint_pkg::CfgSpanLow;
    s.cfg_data = lo;
    pending.push_back(s);
    s.cfg_sel  = ntint_pkg::CfgSpanHigh;
    s.cfg_data = hi;
    pending.push_back(s);
    s.cfg_sel  = ntint_pkg::CfgTableLen;
    s.cfg_data = ntint_pkg::DataW'(len);
    pending.push_back(s);
    settings++;
  endtask

  // Driver: item and config channels, fed from the pending queue.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      item_if.valid       <= 1'b0;
      item_if.op          <= ntint_pkg::OpWrite;
      item_if.sample      <= '0;
      item_if.entry_index <= '0;
      item_if.entry_data  <= '0;
      cfg_if.valid        <= 1'b0;
      cfg_if.index        <= ntint_pkg::CfgSpanLow;
      cfg_if.data         <= '0;
      item_busy = 1'b0;
      cfg_busy  = 1'b0;
      gap_left  = 0;
      quiet     = 0;
      span_lo_q = ntint_pkg::SpanLowRst;
      span_hi_q = ntint_pkg::SpanHighRst;
      len_q     = ntint_pkg::TableLenRst;
    end else begin
      if (item_if.valid && item_if.ready) begin
        if (cur_item.op == ntint_pkg::OpWrite) begin
          table_copy[cur_item.entry_index] = cur_item.entry_data;
          r.mapped = '0;
          r.status = ntint_pkg::StatOk;
        end else begin
          r = interpolate(cur_item.sample);
          maps_sent++;
        end
        expected_results.push_back(r);
        items_sent++;
        item_busy = 1'b0;
        gap_left  = calm_tx ? 0 : $urandom_range(0, 4);
        if (items_sent % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          ntint_pkg::CfgSpanLow:  span_lo_q = cfg_if.data;
          ntint_pkg::CfgSpanHigh: span_hi_q = cfg_if.data;
          ntint_pkg::CfgTableLen: len_q     = cfg_if.data[ntint_pkg::LenW-1:0];
          default: ;
        endcase
        cfg_busy = 1'b0;
      end
      if (item_busy || expected_results.size() != 0) quiet = 0;
      else if (quiet < Settle) quiet++;
      if (!item_busy && !cfg_busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          if (pending[0].kind == StepItem) begin
            cur_item = pending.pop_front();
            item_if.op          <= cur_item.op;
            item_if.sample      <= cur_item.sample;
            item_if.entry_index <= cur_item.entry_index;
            item_if.entry_data  <= cur_item.entry_data;
            item_busy = 1'b1;
          end else if (quiet >= Settle) begin
            // registers change only with the pipeline empty
            if (pending[0].kind == StepCfg) begin
              cfg_if.index <= pending[0].cfg_sel;
              cfg_if.data  <= pending[0].cfg_data;
              cfg_busy = 1'b1;
            end
            void'(pending.pop_front());
          end
        end
      end
      item_if.valid <= item_busy;
      cfg_if.valid  <= cfg_busy;
    end
  end

  // Monitor: stall the result channel at random and check each word.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result word: mapped %0d status %0d",
                   $time, res_if.mapped, res_if.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (res_if.mapped !== want.mapped) begin
            $display("%0t mapped mismatch: expected %0d, actual %0d",
                     $time, want.mapped, res_if.mapped);
            errors++;
          end
          if (res_if.status !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, res_if.status);
            errors++;
          end
        end
        stall_left = calm_rx ? 0 : $urandom_range(0, 4);
        if (results_seen % 50 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      res_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic signed [ntint_pkg::DataW-1:0] lo, hi;
    logic        [ntint_pkg::LenW-1:0]  len;
    int                                 pick;
    rst_ni = 1'b0;

    // Directed: fill every slot first, then map at the reset span [0, 64] and once at a zero span.
    for (int i = 0; i < ntint_pkg::TableDepthDef; i++) begin
      case (i)
        0:       push_write(ntint_pkg::IdxW'(i), 16'sh7FFF);
        1:       push_write(ntint_pkg::IdxW'(i), 16'sh8000);
        2:       push_write(ntint_pkg::IdxW'(i), 16'sh0000);
        3:       push_write(ntint_pkg::IdxW'(i), 16'shFFFF);
        15:      push_write(ntint_pkg::IdxW'(i), 16'sh8000);
        default: push_write(ntint_pkg::IdxW'(i), ntint_pkg::DataW'($urandom));
      endcase
    end
    push_map(16'sh8000);
    push_map(16'sh7FFF);
    push_map(16'sd0);
    push_map(16'sd64);
    push_map(16'sd63);
    push_map(16'sd1);
    push_map(16'sd32);
    push_setting(-16'sd5, -16'sd5, 5'd16);
    push_map(16'sd100);

    // Random phases; a few settings are pinned to the extremes.
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin lo = 16'sh8000; hi = 16'sh7FFF; len = 5'd16; end
        1: begin lo = 16'sh7FFF; hi = 16'sh8000; len = 5'd1;  end
        2: begin
          lo  = ntint_pkg::DataW'($urandom);
          hi  = lo;
          len = ntint_pkg::LenW'($urandom_range(1, 16));
        end
        3: begin lo = 16'sd0; hi = 16'sd640; len = 5'd0; end
        4: begin lo = -16'sd320; hi = 16'sd320; len = 5'd31; end
        default: begin
          lo = ntint_pkg::DataW'($urandom_range(0, 16383) - 8192);
          pick = $urandom_range(1, 4000);
          hi = ($urandom_range(0, 3) == 0) ? lo - ntint_pkg::DataW'(pick)
                                           : lo + ntint_pkg::DataW'(pick);
          len = ($urandom_range(0, 4) == 0) ? ntint_pkg::LenW'($urandom_range(17, 31))
                                            : ntint_pkg::LenW'($urandom_range(1, 16));
        end
      endcase
      push_setting(lo, hi, len);
      for (int k = 0; k < 95; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) push_drain();
        if (pick < 25) begin
          push_write(ntint_pkg::IdxW'($urandom),
                     (pick < 4) ? 16'sh8000 : (pick < 7) ? 16'sh7FFF
                                                         : ntint_pkg::DataW'($urandom));
        end else if (pick < 78) begin
          push_map(sample_near(lo, hi));
        end else begin
          push_map(ntint_pkg::DataW'($urandom));
        end
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending.size() != 0 || item_busy || cfg_busy || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);

    $display("Sent %0d items (%0d maps, %0d table writes) under %0d span/length settings,",
             items_sent, maps_sent, items_sent - maps_sent, settings);
    $display("including zero span and out-of-range lengths; %0d results, %0d mismatches.",
             results_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
